>>> src/afs_pkg.sv
// Shared constants, codes and types of the animation frame stepper.
package afs_pkg;

  localparam int MAX_FRAMES = 256;                    // longest clip
  localparam int POS_W      = $clog2(MAX_FRAMES);     // frame index width
  localparam int CNT_W      = 9;                      // frame_count field
  localparam int RATE_W     = 32;                     // Q15.16 rate
  localparam int TIME_W     = 16;                     // elapsed time units
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_W     = FRAC_BITS + 1;          // signed remnant
  localparam int CFG_W      = RATE_W;                 // widest register
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = RATE_W + TIME_W + 1;    // product plus remnant
  localparam int WHOLE_W    = ACC_W - FRAC_BITS;      // integer step
  localparam int TGT_W      = WHOLE_W + 1;            // position plus step
  localparam int DIV_STEPS  = TGT_W;                  // one quotient bit a cycle
  localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_RESET   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT = 2'd0,
    CFG_RATE        = 2'd1,
    CFG_LOOP_ENABLE = 2'd2,
    CFG_TIME_FROZEN = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_TGT,
    ST_FIT,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [TGT_W-1:0]   magnitude;
    logic [CNT_W-1:0]   divisor;
  } mod_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [CNT_W-1:0]   remainder;
  } mod_rsp_t;

endpackage

>>> src/afs_if.sv
// Valid/ready channel interfaces for step requests and results.
interface afs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [afs_pkg::TIME_W-1:0]  elapsed_time;

  modport source (output valid, output opcode, output elapsed_time, input ready);
  modport sink   (input valid, input opcode, input elapsed_time, output ready);
endinterface

interface afs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [afs_pkg::POS_W-1:0]   frame_index;

  modport source (output valid, output accepted, output frame_index, input ready);
  modport sink   (input valid, input accepted, input frame_index, output ready);
endinterface

>>> src/afs_mod_unit.sv
// Restoring remainder unit: one shift and compare-subtract per cycle.
module afs_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  afs_pkg::mod_req_t req,
  output afs_pkg::mod_rsp_t rsp
);
  import afs_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [TGT_W-1:0]      dvd_r;
  logic [CNT_W-1:0]      rem_r;
  logic [CNT_W-1:0]      divisor_r;

  logic [CNT_W:0]        trial;
  logic [CNT_W-1:0]      rem_nxt;

  // rem_r < divisor <= 256, so the trial value stays below twice the divisor
  always_comb begin
    trial = {rem_r, dvd_r[TGT_W-1]};
    if (trial >= {1'b0, divisor_r}) begin
      rem_nxt = CNT_W'(trial - {1'b0, divisor_r});
    end else begin
      rem_nxt = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= STEP_CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - STEP_CNT_W'(1);
      done_r <= (cnt_r == STEP_CNT_W'(1));
      busy_r <= (cnt_r != STEP_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r     <= req.magnitude;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[TGT_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < divisor_r))
    else $error("remainder not below divisor");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("remainder unit restarted mid-run");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("done without a finished run");

endmodule

>>> src/animation_frame_stepper_top.sv
// Animation frame stepper: fractional phase accumulator with wrap or clamp.
//
// Each input transaction either resets the frame position and remnant, or
// advances the position by rate (signed Q15.16 frames per time unit) times
// elapsed_time plus the carried signed Q0.16 remnant; the integer part is truncated
// toward zero and the rest becomes the new remnant. With loop_enable set the
// new position is the true signed modulo of the sum by the clip length;
// otherwise it is clamped to 0..count-1 and holds at the end it is moving
// towards. frame_count above 256 acts as 256; an empty clip shows index 0.
// While time_frozen is set an advance is answered with accepted = 0 and
// changes nothing. Every input transaction yields exactly one result
// transaction. Reset, frozen, zero-rate and held-at-end requests go from
// accept to emit; a clamped advance goes through accept, 32x17 multiply,
// remnant add, position add, clamp and emit; a looping advance runs the
// 34-step bit-serial remainder unit in place of the clamp. The input is
// not ready while an item is in work; the result sits in an output register,
// so the next transaction can be taken while an earlier result still waits.
// Configuration writes must only happen while the block is idle.
module animation_frame_stepper_top (
  input  logic                          clk,
  input  logic                          rst_n,
  afs_in_if.sink                        in_ch,
  afs_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [afs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afs_pkg::CFG_W-1:0]     cfg_wdata
);
  import afs_pkg::*;

  // configuration registers
  logic [CNT_W-1:0]         frame_count_r;
  logic signed [RATE_W-1:0] rate_r;
  logic                     loop_r;
  logic                     frozen_r;

  // sequencer and architectural state
  state_t                   state_r, state_nxt;
  logic [POS_W-1:0]         pos_r;
  logic [FRAC_W-1:0]        frac_r;

  // per-item working registers
  logic [TIME_W-1:0]        elapsed_r;
  logic                     ok_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic [WHOLE_W-1:0]       whole_r;
  logic [TGT_W-1:0]         target_r;

  // result register
  logic                     out_valid_r;
  logic                     out_accepted_r;
  logic [POS_W-1:0]         out_index_r;

  logic                     in_ready;
  logic                     accept;
  logic                     fast_path;
  logic                     held;
  logic                     emit;
  logic [CNT_W-1:0]         clip_n;
  logic signed [ACC_W-1:0]  prod_full;
  logic [ACC_W-1:0]         acc;
  logic                     round_up;
  logic [WHOLE_W-1:0]       whole;
  logic [FRAC_W-1:0]        rem_frac;
  logic [POS_W-1:0]         clamp_pos;
  logic [POS_W-1:0]         wrap_pos;
  logic                     tgt_neg;
  logic                     mod_start;
  logic [TGT_W-1:0]         mod_mag;
  mod_req_t                 mod_req;
  mod_rsp_t                 mod_rsp;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      rate_r        <= '0;
      loop_r        <= 1'b1;
      frozen_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_COUNT: frame_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_RATE:        rate_r        <= cfg_wdata[RATE_W-1:0];
        CFG_LOOP_ENABLE: loop_r        <= cfg_wdata[0];
        CFG_TIME_FROZEN: frozen_r      <= cfg_wdata[0];
      endcase
    end
  end

  // Oversized counts act as the longest clip.
  assign clip_n = (frame_count_r > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frame_count_r;

  // Clamping and already parked at the end it is heading for: nothing moves.
  assign held = !loop_r &&
                (((rate_r > 0) && ({1'b0, pos_r} == clip_n - CNT_W'(1))) ||
                 ((rate_r < 0) && (pos_r == '0)));

  // Requests that finish without the arithmetic path.
  assign fast_path = (in_ch.opcode == OP_RESET) || frozen_r || (rate_r == 0) || held;

  assign accept = in_ch.valid && in_ready;
  assign emit   = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mod_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = fast_path ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = ST_TGT;
      ST_TGT: state_nxt = ST_FIT;
      ST_FIT: begin
        if (loop_r && (clip_n != '0)) begin
          mod_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (mod_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------- datapath
  // Exact Q.16 product; elapsed time is unsigned, hence the zero bit on top.
  assign prod_full = rate_r * $signed({1'b0, elapsed_r});

  // Add the remnant, then truncate toward zero: floor plus one when negative
  // with fraction bits set. The remnant keeps the sign of the sum.
  assign acc      = prod_r + {{(ACC_W-FRAC_W){frac_r[FRAC_W-1]}}, frac_r};
  assign round_up = acc[ACC_W-1] && (acc[FRAC_BITS-1:0] != '0);
  assign whole    = acc[ACC_W-1:FRAC_BITS] + WHOLE_W'(round_up);
  assign rem_frac = acc[FRAC_W-1:0] - {whole[0], {FRAC_BITS{1'b0}}};

  assign tgt_neg  = target_r[TGT_W-1];

  // Clamp; an empty clip lands on 0.
  always_comb begin
    if (tgt_neg || (clip_n == '0)) begin
      clamp_pos = '0;
    end else if (target_r >= TGT_W'(clip_n)) begin
      clamp_pos = POS_W'(clip_n - CNT_W'(1));
    end else begin
      clamp_pos = target_r[POS_W-1:0];
    end
  end

  assign mod_mag = tgt_neg ? (~target_r + TGT_W'(1)) : target_r;
  // start, magnitude, divisor
  assign mod_req = {mod_start, mod_mag, clip_n};

  // Floored modulo from the magnitude remainder.
  assign wrap_pos = (tgt_neg && (mod_rsp.remainder != '0)) ?
                    POS_W'(clip_n - mod_rsp.remainder) : POS_W'(mod_rsp.remainder);

  afs_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      frac_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_ch.opcode == OP_RESET)) begin
            pos_r  <= '0;
            frac_r <= '0;
          end
        end
        ST_ACC: frac_r <= rem_frac;
        ST_FIT: begin
          if (!loop_r || (clip_n == '0)) begin
            pos_r <= clamp_pos;
          end
        end
        ST_DIV: begin
          if (mod_rsp.done) begin
            pos_r <= wrap_pos;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          elapsed_r <= in_ch.elapsed_time;
          ok_r      <= !((in_ch.opcode == OP_ADVANCE) && frozen_r);
        end
      end
      ST_MUL: prod_r   <= prod_full;
      ST_ACC: whole_r  <= whole;
      ST_TGT: target_r <= {{(TGT_W-POS_W){1'b0}}, pos_r} + {whole_r[WHOLE_W-1], whole_r};
      default: ;
    endcase
  end

  // --------------------------------------------------------- result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_accepted_r <= ok_r;
      out_index_r    <= (clip_n == '0) ? '0 : pos_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_accepted_r;
  assign out_ch.frame_index = out_index_r;

  // ------------------------------------------------------------ assertions
  a_frac_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r != {1'b1, {FRAC_BITS{1'b0}}})
    else $error("remnant reached minus one frame");

  a_frac_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |=> ((frac_r == '0) || (frac_r[FRAC_W-1] == $past(acc[ACC_W-1]))))
    else $error("remnant sign differs from step sign");

  a_wrap_in_clip: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && mod_rsp.done) |=> (CNT_W'(pos_r) < clip_n))
    else $error("wrapped position outside clip");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.busy |-> (state_r == ST_DIV))
    else $error("remainder unit running outside its state");

endmodule
